// ===== rtl/rscp_pkg.sv =====
// ----------------------------------------------------------------------------
// rscp_pkg
// Shared types and constants of the RGBI sync capture packer.
// ----------------------------------------------------------------------------
package rscp_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LEFT_SKIP    = 2'd0;
  localparam logic [1:0] REG_TOP_SKIP     = 2'd1;
  localparam logic [1:0] REG_VSYNC_ENABLE = 2'd2;

  // Result kinds
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // Position and sync counters saturate here
  localparam logic signed [15:0] POS_MAX = 16'sh7fff;
  localparam logic [15:0]        SYNC_COUNT_MAX = 16'hffff;

  // Buffers are requested once more than FRAMES_NEEDED frames were seen; the counter stops one above
  localparam logic [3:0] FRAMES_NEEDED = 4'd10;
  localparam logic [3:0] FRAMES_SAT    = 4'd11;

  typedef struct packed {
    logic [7:0] left_skip;
    logic [7:0] top_skip;
    logic       vsync_enable;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data;
  } result_t;

endpackage

// ===== rtl/rscp_track.sv =====
// ----------------------------------------------------------------------------
// rscp_track
// Sync tracking, position counters and pixel packing for one item a cycle while step is high.
// ----------------------------------------------------------------------------
module rscp_track #(
  parameter int LINE_WIDTH    = 320,
  parameter int FRAME_LINES   = 256,
  parameter int HSYNC_SAMPLES = 64,
  parameter int VSYNC_SAMPLES = 512,
  parameter int HSYNC_BIT     = 6,
  parameter int VSYNC_BIT     = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        sample,
  input  rscp_pkg::cfg_t    cfg,
  output logic              res_valid,
  output rscp_pkg::result_t res
);
  import rscp_pkg::*;

  localparam int          LW_W           = $clog2(LINE_WIDTH + 1);
  localparam int          PROD_W         = 16 + LW_W;
  localparam logic [LW_W-1:0] LW_K       = LW_W'(LINE_WIDTH);
  localparam logic [15:0] LW16           = 16'(LINE_WIDTH);
  localparam logic [15:0] FL16           = 16'(FRAME_LINES);
  localparam logic [15:0] LINE_START_CNT = 16'(HSYNC_SAMPLES / 2);
  localparam logic [15:0] FRAME_CNT      = 16'(VSYNC_SAMPLES);

  logic signed [15:0] x_r, x_nxt;
  logic signed [15:0] y_r, y_nxt;
  logic [15:0]        sc_r, sc_nxt;
  logic [3:0]         held_r, held_nxt;
  logic [15:0]        wp_r, wp_nxt;
  logic [3:0]         fs_r, fs_nxt;
  logic               bv_r, bv_nxt;

  logic signed [15:0] x_inc;
  logic signed [15:0] y_line;
  logic [15:0]        sc_inc;
  logic [PROD_W-1:0]  line_prod;
  logic               in_sync;
  logic               line_start;

  // Sync is active when the selected sync bits are not all high
  assign in_sync = !(sample[HSYNC_BIT] && (!cfg.vsync_enable || sample[VSYNC_BIT]));

  assign x_inc      = (x_r == POS_MAX) ? POS_MAX : x_r + 16'sd1;
  assign line_start = (sc_r == LINE_START_CNT);
  assign y_line     = !line_start ? y_r : ((y_r == POS_MAX) ? POS_MAX : y_r + 16'sd1);
  assign sc_inc     = (sc_r == SYNC_COUNT_MAX) ? sc_r : sc_r + 16'd1;

  // Byte offset of a line start: y * LINE_WIDTH / 2
  assign line_prod = PROD_W'($unsigned(y_line)) * PROD_W'(LW_K);

  // Next state and result
  always_comb begin
    x_nxt     = x_inc;
    y_nxt     = y_r;
    sc_nxt    = sc_r;
    held_nxt  = held_r;
    wp_nxt    = wp_r;
    fs_nxt    = fs_r;
    bv_nxt    = bv_r;
    res_valid = 1'b0;
    res       = '0;
    if (in_sync) begin
      y_nxt  = y_line;
      sc_nxt = sc_inc;
      x_nxt  = ~{8'd0, cfg.left_skip};
      if (line_start && !y_line[15] && bv_r) begin
        wp_nxt = line_prod[16:1];
      end
      if (sc_inc >= FRAME_CNT) begin
        if (!y_line[15]) begin
          if (fs_r > FRAMES_NEEDED) begin
            bv_nxt       = 1'b1;
            res_valid    = 1'b1;
            res.kind     = KIND_REQUEST;
          end
          if (fs_r < FRAMES_SAT) begin
            fs_nxt = fs_r + 4'd1;
          end
        end
        y_nxt = ~{8'd0, cfg.top_skip};
      end
    end else if (x_inc[0]) begin
      // Second pixel of a pair: write if buffers were requested and inside the picture
      if (bv_r && !x_inc[15] && !y_r[15] &&
          ($unsigned(x_inc) < LW16) && ($unsigned(y_r) < FL16)) begin
        res_valid   = 1'b1;
        res.kind    = KIND_WRITE;
        res.address = wp_r;
        res.data    = {sample[3:0], held_r};
        wp_nxt      = wp_r + 16'd1;
      end
    end else begin
      sc_nxt   = '0;
      held_nxt = sample[3:0];
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      sc_r   <= '0;
      held_r <= '0;
      wp_r   <= '0;
      fs_r   <= '0;
      bv_r   <= 1'b0;
    end else if (step) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      sc_r   <= sc_nxt;
      held_r <= held_nxt;
      wp_r   <= wp_nxt;
      fs_r   <= fs_nxt;
      bv_r   <= bv_nxt;
    end
  end

endmodule

// ===== rtl/rgbi_sync_capture_packer_core.sv =====
// ----------------------------------------------------------------------------
// rgbi_sync_capture_packer_core
// Captures RGBI samples, tracks line and frame sync, packs pixel pairs.
// ----------------------------------------------------------------------------
// One sample item is taken every cycle while in_stall is low. Each item
// passes an input register and the tracking logic; its result (a packed
// pixel byte write or a buffer request) enters the output register as the
// item leaves the input register. in_stall rises only while the output
// register holds a result that out_stall keeps from being taken; the state
// counters update in the same cycle that an item leaves the input register.
// Registers: left_skip at 0x0, top_skip at 0x4, vsync_enable at 0x8. The
// user must write them only while no item is in flight; not enforced here.
module rgbi_sync_capture_packer_core #(
  parameter int LINE_WIDTH    = 320,
  parameter int FRAME_LINES   = 256,
  parameter int HSYNC_SAMPLES = 64,
  parameter int VSYNC_SAMPLES = 512,
  parameter int HSYNC_BIT     = 6,
  parameter int VSYNC_BIT     = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_sample,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [15:0] out_address,
  output logic [7:0]  out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rscp_pkg::*;

  cfg_t       cfg_r;
  logic       in_valid_r;
  logic [7:0] in_sample_r;
  logic       out_valid_r;
  result_t    out_r;
  logic       adv;
  logic       step;
  logic       res_valid;
  result_t    res;
  logic [1:0] reg_idx;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_LEFT_SKIP:    cfg_r.left_skip    <= pwdata[7:0];
        REG_TOP_SKIP:     cfg_r.top_skip     <= pwdata[7:0];
        REG_VSYNC_ENABLE: cfg_r.vsync_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEFT_SKIP:    prdata = {24'd0, cfg_r.left_skip};
      REG_TOP_SKIP:     prdata = {24'd0, cfg_r.top_skip};
      REG_VSYNC_ENABLE: prdata = {31'd0, cfg_r.vsync_enable};
      default:          prdata = '0;
    endcase
  end

  // Pipeline control
  assign adv      = !out_valid_r || !out_stall;
  assign step     = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_sample_r <= in_sample;
    end
  end

  rscp_track #(
    .LINE_WIDTH    (LINE_WIDTH),
    .FRAME_LINES   (FRAME_LINES),
    .HSYNC_SAMPLES (HSYNC_SAMPLES),
    .VSYNC_SAMPLES (VSYNC_SAMPLES),
    .HSYNC_BIT     (HSYNC_BIT),
    .VSYNC_BIT     (VSYNC_BIT)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .sample    (in_sample_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_r.kind;
  assign out_address = out_r.address;
  assign out_data    = out_r.data;

endmodule
